// ===== rtl/core/lru_page_replacement_defines.svh =====
// Assertion macros used by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define LPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/lpr_pkg.sv =====
// Payload types and fixed field widths of the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;

  localparam int CFG_W   = 5;
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              start_new;
  } lpr_req_t;

  typedef struct packed {
    logic               was_hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] fault_total;
  } lpr_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
// Top level of the LRU page replacement engine: sequencer, frame walk and totals.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_defines.svh"
// Usage:
//   A request beat is taken at a clock edge with start high and busy low; req_i
//   carries the page number and start_new, which clears the frame valid bits and the
//   hit and fault totals before the request is handled.
//   The result beat is on rsp_o, marked by done_o, which is high for exactly one
//   cycle. There is no backpressure: the receiver must take it in that cycle.
//   cfg_we_i writes frames_in_use from cfg_wdata_i; write only while busy is low
//   and no result is pending.
// Sequencing:
//   With n active frames (frames_in_use clamped to 1..FRAMES) a request is
//   handled in a search walk, a decide step and an aging walk, and the next
//   request can be accepted in the cycle the result is shown. The frame store
//   has a single read port, so it is walked once to search for a hit and the
//   oldest frame and once more to age the recency ranks.
// Reset:
//   Reset clears the valid bits, the fill count and both totals and sets
//   frames_in_use to 16; page and rank storage is not cleared.
module lru_page_replacement #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lpr_pkg::lpr_req_t          req_i,
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output lpr_pkg::lpr_rsp_t          rsp_o
);
  import lpr_pkg::*;

  localparam int SW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW  = $clog2(FRAMES + 1);
  localparam int MW  = (NW > CFG_W) ? NW : CFG_W;
  localparam int PW  = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int CW  = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam int SLW = (SW > SLOT_W) ? SW : SLOT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_AGE    = 2'd3;

  localparam logic [SW-1:0] RANK_MAX = SW'(FRAMES - 1);

  // Control state.
  logic [1:0]            state_q, state_d;
  logic [CFG_W-1:0]      fiu_q, fiu_d;
  logic [NW-1:0]         iss_q, iss_d;
  logic                  ev_vld_q, ev_vld_d;
  logic                  ev_fv_q, ev_fv_d;
  logic [FRAMES-1:0]     valid_q, valid_d;
  logic [NW-1:0]         filled_q, filled_d;
  logic [COUNT_BITS-1:0] hits_q, hits_d;
  logic [COUNT_BITS-1:0] faults_q, faults_d;
  logic                  hit_q, hit_d;
  logic                  lru_q, lru_d;
  logic                  nolim_q, nolim_d;
  logic                  evict_q, evict_d;
  logic                  done_q, done_d;

  // Payload state.
  logic [NW-1:0]         n_q, n_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [SW-1:0]         ev_idx_q, ev_idx_d;
  logic [SW-1:0]         hit_slot_q, hit_slot_d;
  logic [SW-1:0]         hit_rank_q, hit_rank_d;
  logic [SW-1:0]         lru_slot_q, lru_slot_d;
  logic [SW-1:0]         lru_rank_q, lru_rank_d;
  logic [PAGE_BITS-1:0]  lru_page_q, lru_page_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic [SW-1:0]         limit_q, limit_d;
  lpr_rsp_t              rsp_q, rsp_d;

  // Store interface.
  logic [PAGE_BITS-1:0]  rd_page;
  logic [SW-1:0]         rd_rank;
  logic [SW-1:0]         wr_addr;
  logic                  wr_page_en;
  logic                  wr_rank_en;
  logic [SW-1:0]         wr_rank;

  // Helpers.
  logic                  accept;
  logic                  issue;
  logic [MW-1:0]         cfg_wide;
  logic [MW-1:0]         n_act;
  logic [PW-1:0]         page_in_wide;
  logic [PW-1:0]         evict_wide;
  logic [SLW-1:0]        slot_wide;
  logic [CW-1:0]         hits_wide;
  logic [CW-1:0]         faults_wide;
  logic                  page_match;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (iss_q < n_q);

  assign cfg_wide     = MW'(fiu_q);
  assign page_in_wide = PW'(req_i.page);
  assign page_match   = ev_fv_q && (rd_page == page_q);

  always_comb begin
    if (cfg_wide == '0) begin
      n_act = MW'(1);
    end else if (cfg_wide > MW'(FRAMES)) begin
      n_act = MW'(FRAMES);
    end else begin
      n_act = cfg_wide;
    end
  end

  lpr_frame_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rd_addr_i    (iss_q[SW-1:0]),
    .rd_page_o    (rd_page),
    .rd_rank_o    (rd_rank),
    .wr_addr_i    (wr_addr),
    .wr_page_en_i (wr_page_en),
    .wr_page_i    (page_q),
    .wr_rank_en_i (wr_rank_en),
    .wr_rank_i    (wr_rank)
  );

  always_comb begin
    state_d    = state_q;
    fiu_d      = cfg_we_i ? cfg_wdata_i : fiu_q;
    iss_d      = iss_q;
    ev_vld_d   = 1'b0;
    ev_fv_d    = 1'b0;
    ev_idx_d   = iss_q[SW-1:0];
    valid_d    = valid_q;
    filled_d   = filled_q;
    hits_d     = hits_q;
    faults_d   = faults_q;
    hit_d      = hit_q;
    lru_d      = lru_q;
    nolim_d    = nolim_q;
    evict_d    = evict_q;
    done_d     = 1'b0;
    n_d        = n_q;
    page_d     = page_q;
    hit_slot_d = hit_slot_q;
    hit_rank_d = hit_rank_q;
    lru_slot_d = lru_slot_q;
    lru_rank_d = lru_rank_q;
    lru_page_d = lru_page_q;
    slot_d     = slot_q;
    limit_d    = limit_q;
    rsp_d      = rsp_q;
    wr_addr    = ev_idx_q;
    wr_page_en = 1'b0;
    wr_rank_en = 1'b0;
    wr_rank    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          page_d = page_in_wide[PAGE_BITS-1:0];
          n_d    = n_act[NW-1:0];
          iss_d  = '0;
          hit_d  = 1'b0;
          lru_d  = 1'b0;
          if (req_i.start_new) begin
            valid_d  = '0;
            filled_d = '0;
            hits_d   = '0;
            faults_d = '0;
          end
          state_d = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (issue) begin
          iss_d    = iss_q + 1'b1;
          ev_vld_d = 1'b1;
          ev_fv_d  = valid_q[iss_q[SW-1:0]];
        end
        // One frame per beat through the compare unit: the first match wins,
        // and the oldest rank is kept with ties going to the lower index.
        if (ev_vld_q) begin
          if (page_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_slot_d = ev_idx_q;
            hit_rank_d = rd_rank;
          end
          if (ev_fv_q && (!lru_q || (rd_rank > lru_rank_q))) begin
            lru_d      = 1'b1;
            lru_slot_d = ev_idx_q;
            lru_rank_d = rd_rank;
            lru_page_d = rd_page;
          end
        end
        if (!issue) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        evict_d = 1'b0;
        nolim_d = 1'b0;
        if (hit_q) begin
          slot_d  = hit_slot_q;
          limit_d = hit_rank_q;
          hits_d  = (hits_q == '1) ? hits_q : hits_q + 1'b1;
        end else begin
          if (filled_q < n_q) begin
            slot_d   = filled_q[SW-1:0];
            filled_d = filled_q + 1'b1;
            nolim_d  = 1'b1;
          end else if (lru_q) begin
            slot_d  = lru_slot_q;
            limit_d = lru_rank_q;
            evict_d = 1'b1;
          end else begin
            // Full table with no valid active frame: reuse frame zero.
            slot_d  = '0;
            nolim_d = 1'b1;
          end
          wr_addr          = slot_d;
          wr_page_en       = 1'b1;
          valid_d[slot_d]  = 1'b1;
          faults_d         = (faults_q == '1) ? faults_q : faults_q + 1'b1;
        end
        iss_d   = '0;
        state_d = ST_AGE;
      end

      ST_AGE: begin
        if (issue) begin
          iss_d    = iss_q + 1'b1;
          ev_vld_d = 1'b1;
          ev_fv_d  = valid_q[iss_q[SW-1:0]];
        end
        if (ev_vld_q) begin
          if (ev_idx_q == slot_q) begin
            wr_rank_en = 1'b1;
            wr_rank    = '0;
          end else if (ev_fv_q && (nolim_q || (rd_rank < limit_q)) &&
                       (rd_rank < RANK_MAX)) begin
            wr_rank_en = 1'b1;
            wr_rank    = rd_rank + 1'b1;
          end
        end
        if (!issue) begin
          rsp_d.was_hit       = hit_q;
          rsp_d.frame_slot    = slot_wide[SLOT_W-1:0];
          rsp_d.evicted_page  = evict_q ? evict_wide[PAGE_W-1:0] : '0;
          rsp_d.evicted_valid = evict_q;
          rsp_d.hit_total     = hits_wide[TOTAL_W-1:0];
          rsp_d.fault_total   = faults_wide[TOTAL_W-1:0];
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign evict_wide  = PW'(lru_page_q);
  assign slot_wide   = SLW'(slot_q);
  assign hits_wide   = CW'(hits_q);
  assign faults_wide = CW'(faults_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fiu_q    <= FRAMES_IN_USE_RESET;
      iss_q    <= '0;
      ev_vld_q <= 1'b0;
      ev_fv_q  <= 1'b0;
      valid_q  <= '0;
      filled_q <= '0;
      hits_q   <= '0;
      faults_q <= '0;
      hit_q    <= 1'b0;
      lru_q    <= 1'b0;
      nolim_q  <= 1'b0;
      evict_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fiu_q    <= fiu_d;
      iss_q    <= iss_d;
      ev_vld_q <= ev_vld_d;
      ev_fv_q  <= ev_fv_d;
      valid_q  <= valid_d;
      filled_q <= filled_d;
      hits_q   <= hits_d;
      faults_q <= faults_d;
      hit_q    <= hit_d;
      lru_q    <= lru_d;
      nolim_q  <= nolim_d;
      evict_q  <= evict_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    page_q     <= page_d;
    ev_idx_q   <= ev_idx_d;
    hit_slot_q <= hit_slot_d;
    hit_rank_q <= hit_rank_d;
    lru_slot_q <= lru_slot_d;
    lru_rank_q <= lru_rank_d;
    lru_page_q <= lru_page_d;
    slot_q     <= slot_d;
    limit_q    <= limit_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `LPR_ASSERT(a_done_after_age, clk_i, rst_ni, done_q |-> $past(state_q == ST_AGE), "result beat without an aging pass")
  `LPR_ASSERT(a_hit_no_evict, clk_i, rst_ni, done_q |-> !(rsp_q.was_hit && rsp_q.evicted_valid), "hit reported with an eviction")
  `LPR_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> (busy && !done_q), "accepted request did not raise busy")
  `LPR_ASSERT(a_fill_bound, clk_i, rst_ni, filled_q <= NW'(FRAMES), "fill count beyond frame count")
  `LPR_ASSERT_ALWAYS(a_no_done_in_reset, clk_i, !rst_ni |=> !done_o, "result beat during reset")

endmodule
`default_nettype wire

// ===== rtl/core/lpr_frame_store.sv =====
// Frame table storage: resident page and recency rank per frame, one read port.
`timescale 1ns / 1ps
`default_nettype none
module lpr_frame_store #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  localparam int SW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic [SW-1:0]        rd_addr_i,
  output logic [PAGE_BITS-1:0] rd_page_o,
  output logic [SW-1:0]        rd_rank_o,
  input  logic [SW-1:0]        wr_addr_i,
  input  logic                 wr_page_en_i,
  input  logic [PAGE_BITS-1:0] wr_page_i,
  input  logic                 wr_rank_en_i,
  input  logic [SW-1:0]        wr_rank_i
);

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [SW-1:0]        rank_mem [FRAMES];

  always_ff @(posedge clk_i) begin
    if (wr_page_en_i) begin
      page_mem[wr_addr_i] <= wr_page_i;
    end
    if (wr_rank_en_i) begin
      rank_mem[wr_addr_i] <= wr_rank_i;
    end
    rd_page_o <= page_mem[rd_addr_i];
    rd_rank_o <= rank_mem[rd_addr_i];
  end

endmodule
`default_nettype wire
